FILE: rtl/core/ftk_pkg.sv
// ----------------------------------------------------------------------------
// ftk_pkg
// Shared widths, register codes and control types of the top-K tracker.
// ----------------------------------------------------------------------------
package ftk_pkg;

    localparam int METRIC_W = 31;
    localparam int KIND_W   = 4;
    localparam int RANK_W   = 3;
    localparam int ADDR_W   = 5;
    localparam int APB_W    = 32;

    // rank order codes
    localparam logic ORDER_HIGH = 1'b0;
    localparam logic ORDER_LOW  = 1'b1;

    // owner filter modes
    localparam logic [1:0] OWN_ALL  = 2'd0;
    localparam logic [1:0] OWN_FREE = 2'd1;
    localparam logic [1:0] OWN_ONE  = 2'd2;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_RANK_ORDER  = 3'd0;
    localparam logic [2:0] REG_OWNER_MODE  = 3'd1;
    localparam logic [2:0] REG_OWNER_SEL   = 3'd2;
    localparam logic [2:0] REG_TYPE_EN     = 3'd3;
    localparam logic [2:0] REG_TYPE_SEL    = 3'd4;

    typedef struct packed {
        logic insert;   // place the staged record into the list
        logic clear;    // empty the list after this update
        logic order;    // ORDER_HIGH or ORDER_LOW
    } ftk_ctrl_t;

endpackage

FILE: rtl/core/filtered_top_k_tracker_unit.sv
// ----------------------------------------------------------------------------
// filtered_top_k_tracker_unit
// Filtered top-K tracker: keeps the LIST_DEPTH best records of a stream.
// ----------------------------------------------------------------------------
// Input stream (s_axis): one record per request; tlast marks the final
// record of a run. A record that passes the kind and owner filters is placed
// in a ranked list (highest or lowest metric first, ties keep the earlier).
// Throughput is one record per cycle unless a final record is held: the
// record sits in the input register while the list is compared and shifted
// in a single pass. On the final record the updated list is copied to an
// output buffer and the list is cleared; the buffer then sends LIST_DEPTH
// results on m_axis, one per cycle while m_axis_tready is high, best first,
// tlast on the last. The buffer is loaded as the final record leaves the
// input register. Records keep flowing while the buffer drains; a final
// record waits in the input register (tready low) until the previous run
// has fully left, so a stalled receiver eventually holds the input side too.
// Reset empties the list and the buffer and clears the configuration to zero.
// Configure through the APB port only while the stream is idle.
// ----------------------------------------------------------------------------
module filtered_top_k_tracker_unit
    import ftk_pkg::*;
#(
    parameter int LIST_DEPTH  = 5,
    parameter int OWNER_COUNT = 64,
    parameter int COORD_BITS  = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    // APB configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready,
    // record input
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // metric, pos_x, pos_y, owner, zero fill
    input  logic [((METRIC_W+2*COORD_BITS+$clog2(OWNER_COUNT)+7)/8)*8-1:0] s_axis_tdata,
    // kind
    input  logic [KIND_W-1:0] s_axis_tuser,
    input  logic              s_axis_tlast,
    // ranked results
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // rank, out_metric, out_x, out_y, zero fill
    output logic [((RANK_W+METRIC_W+2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
    // entry_valid, out_kind
    output logic [KIND_W:0]   m_axis_tuser,
    output logic              m_axis_tlast
);

    localparam int OWNER_W = $clog2(OWNER_COUNT);
    localparam int OUT_W   = RANK_W + METRIC_W + 2*COORD_BITS;
    localparam int OUT_TW  = ((OUT_W + 7) / 8) * 8;
    localparam int DATA_W  = METRIC_W + 2*COORD_BITS + KIND_W;
    localparam int CNT_W   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    typedef struct packed {
        logic [METRIC_W-1:0]   metric;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [KIND_W-1:0]     kind;
    } entry_t;

    // configuration
    logic                rank_order_reg;
    logic [1:0]          owner_mode_reg;
    logic [OWNER_W-1:0]  owner_sel_reg;
    logic                type_en_reg;
    logic [KIND_W-1:0]   type_sel_reg;
    logic                cfg_wr;
    logic [2:0]          cfg_idx;

    // input register
    logic                s1_valid_reg;
    logic                s1_last_reg;
    logic [METRIC_W-1:0] s1_metric_reg;
    logic [COORD_BITS-1:0] s1_x_reg;
    logic [COORD_BITS-1:0] s1_y_reg;
    logic [KIND_W-1:0]   s1_kind_reg;
    logic [OWNER_W-1:0]  s1_owner_reg;
    logic                s1_go;
    logic                owner_ok;
    logic                kind_ok;
    ftk_ctrl_t           ctrl;

    // list and output buffer
    logic [LIST_DEPTH-1:0] post_valid;
    logic [DATA_W-1:0]     post_data [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] snap_valid_reg;
    logic [DATA_W-1:0]     snap_data_reg [LIST_DEPTH];
    logic                  busy_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  cnt_end;
    logic                  out_take;
    logic                  cur_valid;
    entry_t                cur;

    // ------------------------------------------------------------------
    // APB registers
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_order_reg <= ORDER_HIGH;
            owner_mode_reg <= OWN_ALL;
            owner_sel_reg  <= '0;
            type_en_reg    <= 1'b0;
            type_sel_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_RANK_ORDER: rank_order_reg <= pwdata[0];
                REG_OWNER_MODE: owner_mode_reg <= pwdata[1:0];
                REG_OWNER_SEL:  owner_sel_reg  <= pwdata[OWNER_W-1:0];
                REG_TYPE_EN:    type_en_reg    <= pwdata[0];
                REG_TYPE_SEL:   type_sel_reg   <= pwdata[KIND_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_RANK_ORDER: prdata = APB_W'(rank_order_reg);
            REG_OWNER_MODE: prdata = APB_W'(owner_mode_reg);
            REG_OWNER_SEL:  prdata = APB_W'(owner_sel_reg);
            REG_TYPE_EN:    prdata = APB_W'(type_en_reg);
            REG_TYPE_SEL:   prdata = APB_W'(type_sel_reg);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    // a final record holds while the previous run still drains
    assign s1_go         = !(s1_last_reg && busy_reg);
    assign s_axis_tready = !s1_valid_reg || s1_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            s1_metric_reg <= s_axis_tdata[METRIC_W-1:0];
            s1_x_reg      <= s_axis_tdata[METRIC_W +: COORD_BITS];
            s1_y_reg      <= s_axis_tdata[METRIC_W+COORD_BITS +: COORD_BITS];
            s1_owner_reg  <= s_axis_tdata[METRIC_W+2*COORD_BITS +: OWNER_W];
            s1_kind_reg   <= s_axis_tuser;
            s1_last_reg   <= s_axis_tlast;
        end
    end

    always_comb
    begin
        case (owner_mode_reg)
            OWN_ALL:  owner_ok = 1'b1;
            OWN_FREE: owner_ok = (s1_owner_reg == '0);
            OWN_ONE:  owner_ok = (s1_owner_reg == owner_sel_reg);
            default:  owner_ok = 1'b0;
        endcase
    end

    assign kind_ok     = !type_en_reg || (s1_kind_reg == type_sel_reg);
    assign ctrl.insert = s1_valid_reg && s1_go && kind_ok && owner_ok;
    assign ctrl.clear  = s1_valid_reg && s1_go && s1_last_reg;
    assign ctrl.order  = rank_order_reg;

    ftk_rank_list #(
        .LIST_DEPTH (LIST_DEPTH),
        .COORD_BITS (COORD_BITS)
    ) u_list (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .rec_metric (s1_metric_reg),
        .rec_x      (s1_x_reg),
        .rec_y      (s1_y_reg),
        .rec_kind   (s1_kind_reg),
        .post_valid (post_valid),
        .post_data  (post_data)
    );

    // ------------------------------------------------------------------
    // Output buffer
    // ------------------------------------------------------------------
    assign out_take = m_axis_tvalid && m_axis_tready;
    assign cnt_end  = (cnt_reg == CNT_W'(LIST_DEPTH - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            cnt_reg        <= '0;
            snap_valid_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            busy_reg       <= 1'b1;
            cnt_reg        <= '0;
            snap_valid_reg <= post_valid;
        end
        else if (out_take)
        begin
            if (cnt_end)
            begin
                busy_reg <= 1'b0;
                cnt_reg  <= '0;
            end
            else
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            snap_data_reg <= post_data;
        end
    end

    assign cur_valid = snap_valid_reg[cnt_reg];
    // empty slots read as zero
    assign cur = cur_valid ? entry_t'(snap_data_reg[cnt_reg]) : '0;

    assign m_axis_tvalid = busy_reg;
    assign m_axis_tlast  = cnt_end;
    assign m_axis_tuser  = {cur.kind, cur_valid};
    assign m_axis_tdata  = OUT_TW'({cur.y, cur.x, cur.metric, RANK_W'(cnt_reg)});

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg <= CNT_W'(LIST_DEPTH - 1)))
        else $error("result counter beyond list depth");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (s1_valid_reg && s1_last_reg && busy_reg))
        else $error("input stalled without a pending final record");

    a_run_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !busy_reg)
        else $error("output buffer still busy after last result");

    a_snap_packed: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> ((snap_valid_reg & (snap_valid_reg + LIST_DEPTH'(1))) == '0))
        else $error("valid entries of snapshot not contiguous from rank 0");
`endif

endmodule

FILE: rtl/core/ftk_rank_list.sv
// ----------------------------------------------------------------------------
// ftk_rank_list
// Ranked list registers with combinational insertion and a registered clear.
// ----------------------------------------------------------------------------
module ftk_rank_list
    import ftk_pkg::*;
#(
    parameter int LIST_DEPTH = 5,
    parameter int COORD_BITS = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ftk_ctrl_t              ctrl,
    input  logic [METRIC_W-1:0]    rec_metric,
    input  logic [COORD_BITS-1:0]  rec_x,
    input  logic [COORD_BITS-1:0]  rec_y,
    input  logic [KIND_W-1:0]      rec_kind,
    output logic [LIST_DEPTH-1:0]  post_valid,
    output logic [METRIC_W+2*COORD_BITS+KIND_W-1:0] post_data [LIST_DEPTH]
);

    localparam int DATA_W = METRIC_W + 2*COORD_BITS + KIND_W;

    typedef struct packed {
        logic [METRIC_W-1:0]   metric;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [KIND_W-1:0]     kind;
    } entry_t;

    logic [LIST_DEPTH-1:0] valid_reg;
    entry_t                data_reg [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] here;
    logic [LIST_DEPTH-1:0] first;
    logic [LIST_DEPTH-1:0] shift;
    entry_t                rec;

    assign rec = '{metric: rec_metric, x: rec_x, y: rec_y, kind: rec_kind};

    genvar gi;
    generate
        for (gi = 0; gi < LIST_DEPTH; gi++)
        begin : g_slot
            logic [LIST_DEPTH-1:0] lower;
            assign lower = {LIST_DEPTH{1'b1}} >> (LIST_DEPTH - gi);
            // empty slot, or strictly worse than the new record
            assign here[gi] = !valid_reg[gi] ||
                              ((ctrl.order == ORDER_HIGH) ? (data_reg[gi].metric < rec.metric)
                                                          : (data_reg[gi].metric > rec.metric));
            assign first[gi] = here[gi] && ((here & lower) == '0);
            assign shift[gi] = (here & lower) != '0;

            if (gi == 0)
            begin : g_head
                always_comb
                begin
                    post_valid[gi] = valid_reg[gi];
                    post_data[gi]  = DATA_W'(data_reg[gi]);
                    if (ctrl.insert && first[gi])
                    begin
                        post_valid[gi] = 1'b1;
                        post_data[gi]  = DATA_W'(rec);
                    end
                end
            end
            else
            begin : g_tail
                always_comb
                begin
                    post_valid[gi] = valid_reg[gi];
                    post_data[gi]  = DATA_W'(data_reg[gi]);
                    if (ctrl.insert && first[gi])
                    begin
                        post_valid[gi] = 1'b1;
                        post_data[gi]  = DATA_W'(rec);
                    end
                    else if (ctrl.insert && shift[gi])
                    begin
                        // move down one slot behind the insertion point
                        post_valid[gi] = valid_reg[gi-1];
                        post_data[gi]  = DATA_W'(data_reg[gi-1]);
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                data_reg[gi] <= entry_t'(post_data[gi]);
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= post_valid;
        end
    end

endmodule

FILE: sim/ftk_rank_checker.sv
// ----------------------------------------------------------------------------
// ftk_rank_checker
// Stream checker for the top-K tracker: mirrors the APB register writes,
// keeps its own ranked list from the accepted records and compares every
// result on the output stream, field by field, with the oldest expected one.
// ----------------------------------------------------------------------------
module ftk_rank_checker
    import ftk_pkg::*;
#(
    parameter int LIST_DEPTH = 5,
    parameter int REC_W      = 56,
    parameter int RES_W      = 56
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    input  logic              pready,
    input  logic              s_axis_tvalid,
    input  logic              s_axis_tready,
    input  logic [REC_W-1:0]  s_axis_tdata,
    input  logic [KIND_W-1:0] s_axis_tuser,
    input  logic              s_axis_tlast,
    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic [RES_W-1:0]  m_axis_tdata,
    input  logic [KIND_W:0]   m_axis_tuser,
    input  logic              m_axis_tlast,
    output int                mismatches,
    output int                ranks_due
);

    localparam int XY_W  = 8;
    localparam int OWN_W = 6;

    typedef struct packed {
        logic                used;
        logic [METRIC_W-1:0] metric;
        logic [XY_W-1:0]     x;
        logic [XY_W-1:0]     y;
        logic [KIND_W-1:0]   kind;
    } slot_t;

    typedef struct packed {
        slot_t             entry;
        logic [RANK_W-1:0] rank;
        logic              tail;
    } ranked_t;

    slot_t       board [LIST_DEPTH];
    ranked_t     ranking_q [$];
    int          tally;

    logic        keep_order;
    logic [1:0]  owner_mode;
    logic [5:0]  owner_pick;
    logic        kind_gate;
    logic [3:0]  kind_pick;

    function automatic logic owner_admitted(logic [OWN_W-1:0] who);
        case (owner_mode)
            OWN_ALL:  return 1'b1;
            OWN_FREE: return who == '0;
            OWN_ONE:  return who == owner_pick;
            default:  return 1'b0;
        endcase
    endfunction

    // Insert ahead of the first empty or strictly worse entry; the tail drops.
    function automatic void insert_record(slot_t rec);
        int   spot;
        int   i;
        logic beaten;
        spot = -1;
        for (i = 0; i < LIST_DEPTH; i++)
        begin
            if (spot < 0)
            begin
                if (!board[i].used)
                    beaten = 1'b1;
                else if (keep_order == ORDER_HIGH)
                    beaten = board[i].metric < rec.metric;
                else
                    beaten = board[i].metric > rec.metric;
                if (beaten)
                    spot = i;
            end
        end
        if (spot >= 0)
        begin
            for (i = LIST_DEPTH - 1; i > spot; i--)
                board[i] = board[i-1];
            board[spot] = rec;
        end
    endfunction

    function automatic void check_field(string name, logic [RANK_W-1:0] rank,
                                        logic [METRIC_W-1:0] want,
                                        logic [METRIC_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: rank %0d %s expected %0h actual %0h",
                     $time, rank, name, want, got);
            tally++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        slot_t           rec;
        ranked_t         want;
        logic [OWN_W-1:0] who;
        int              i;
        if (!rst_n)
        begin
            for (i = 0; i < LIST_DEPTH; i++)
                board[i] = '0;
            ranking_q.delete();
            tally      = 0;
            keep_order = ORDER_HIGH;
            owner_mode = OWN_ALL;
            owner_pick = '0;
            kind_gate  = 1'b0;
            kind_pick  = '0;
            mismatches <= 0;
            ranks_due  <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:2])
                    REG_RANK_ORDER: keep_order = pwdata[0];
                    REG_OWNER_MODE: owner_mode = pwdata[1:0];
                    REG_OWNER_SEL:  owner_pick = pwdata[5:0];
                    REG_TYPE_EN:    kind_gate  = pwdata[0];
                    REG_TYPE_SEL:   kind_pick  = pwdata[3:0];
                    default: ;
                endcase
            end

            // Compare before queuing, so a result never matches its own request.
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (ranking_q.size() == 0)
                begin
                    $display("%0t: result rank %0d expected none actual %0h",
                             $time, m_axis_tdata[RANK_W-1:0], m_axis_tdata);
                    tally++;
                end
                else
                begin
                    want = ranking_q.pop_front();
                    check_field("entry_valid", want.rank, METRIC_W'(want.entry.used),
                                METRIC_W'(m_axis_tuser[0]));
                    check_field("rank", want.rank, METRIC_W'(want.rank),
                                METRIC_W'(m_axis_tdata[RANK_W-1:0]));
                    check_field("metric", want.rank, want.entry.metric,
                                m_axis_tdata[RANK_W +: METRIC_W]);
                    check_field("x", want.rank, METRIC_W'(want.entry.x),
                                METRIC_W'(m_axis_tdata[RANK_W+METRIC_W +: XY_W]));
                    check_field("y", want.rank, METRIC_W'(want.entry.y),
                                METRIC_W'(m_axis_tdata[RANK_W+METRIC_W+XY_W +: XY_W]));
                    check_field("kind", want.rank, METRIC_W'(want.entry.kind),
                                METRIC_W'(m_axis_tuser[KIND_W:1]));
                    check_field("list_end", want.rank, METRIC_W'(want.tail),
                                METRIC_W'(m_axis_tlast));
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                rec.used   = 1'b1;
                rec.metric = s_axis_tdata[METRIC_W-1:0];
                rec.x      = s_axis_tdata[METRIC_W +: XY_W];
                rec.y      = s_axis_tdata[METRIC_W+XY_W +: XY_W];
                who        = s_axis_tdata[METRIC_W+2*XY_W +: OWN_W];
                rec.kind   = s_axis_tuser;
                if ((!kind_gate || rec.kind == kind_pick) && owner_admitted(who))
                    insert_record(rec);
                // Final record: emit the whole list best first, then empty it.
                if (s_axis_tlast)
                begin
                    for (i = 0; i < LIST_DEPTH; i++)
                    begin
                        want.entry = board[i];
                        want.rank  = i[RANK_W-1:0];
                        want.tail  = (i == LIST_DEPTH - 1);
                        ranking_q.insert(ranking_q.size(), want);
                        board[i] = '0;
                    end
                end
            end

            mismatches <= tally;
            ranks_due  <= ranking_q.size();
        end
    end

endmodule

FILE: sim/filtered_top_k_tracker_unit_test.sv
// ----------------------------------------------------------------------------
// filtered_top_k_tracker_unit_test
// Drives records and APB register writes into the top-K tracker under random
// idling and backpressure; a separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module filtered_top_k_tracker_unit_test;
    import ftk_pkg::*;

    localparam int LIST_DEPTH     = 5;
    localparam int XY_W           = 8;
    localparam int OWN_W          = 6;
    localparam int REC_W          = ((METRIC_W + 2*XY_W + OWN_W + 7) / 8) * 8;
    localparam int RES_W          = ((RANK_W + METRIC_W + 2*XY_W + 7) / 8) * 8;
    localparam int RANDOM_RECORDS = 150;
    localparam int HOLDOFF_CYCLES = 80;
    localparam int DRAIN_CYCLES   = 6;
    localparam int QUIET_LIMIT    = 2000;

    // owner filter mode that is not defined: every record is rejected
    localparam logic [1:0]          OWN_NONE   = 2'd3;
    localparam logic [METRIC_W-1:0] METRIC_TOP = '1;

    typedef struct packed {
        logic [METRIC_W-1:0] metric;
        logic [XY_W-1:0]     x;
        logic [XY_W-1:0]     y;
        logic [KIND_W-1:0]   kind;
        logic [OWN_W-1:0]    owner;
        logic                closing;
    } record_t;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [ADDR_W-1:0] paddr         = '0;
    logic [APB_W-1:0]  pwdata        = '0;
    logic [APB_W-1:0]  prdata;
    logic              pready;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    // metric, pos_x, pos_y, owner, zero fill
    logic [REC_W-1:0]  s_axis_tdata  = '0;
    // kind
    logic [KIND_W-1:0] s_axis_tuser  = '0;
    logic              s_axis_tlast  = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // rank, out_metric, out_x, out_y, zero fill
    logic [RES_W-1:0]  m_axis_tdata;
    // entry_valid, out_kind
    logic [KIND_W:0]   m_axis_tuser;
    logic              m_axis_tlast;

    int                mismatches;
    int                ranks_due;
    logic              steady         = 1'b0;
    int                holdoff_asked  = 0;
    int                holdoff_taken  = 0;
    int                holdoff_left   = 0;
    int                quiet_cycles   = 0;
    int                random_sent    = 0;

    logic [1:0]        cur_mode;
    logic [5:0]        cur_owner;
    logic              cur_kind_en;
    logic [3:0]        cur_kind;

    always #6 clk = ~clk;

    filtered_top_k_tracker_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    ftk_rank_checker #(
        .LIST_DEPTH (LIST_DEPTH),
        .REC_W      (REC_W),
        .RES_W      (RES_W)
    ) ranks
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .mismatches    (mismatches),
        .ranks_due     (ranks_due)
    );

    // Result receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (holdoff_left > 0)
        begin
            m_axis_tready <= 1'b0;
            holdoff_left  <= holdoff_left - 1;
        end
        else if (holdoff_taken != holdoff_asked)
        begin
            holdoff_taken <= holdoff_asked;
            holdoff_left  <= HOLDOFF_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= steady || ($urandom_range(99) >= 8);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic write_reg(logic [2:0] idx, logic [APB_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(logic order, logic [1:0] mode, logic [5:0] who,
                             logic gate, logic [3:0] pick);
        write_reg(REG_RANK_ORDER, APB_W'(order));
        write_reg(REG_OWNER_MODE, APB_W'(mode));
        write_reg(REG_OWNER_SEL, APB_W'(who));
        write_reg(REG_TYPE_EN, APB_W'(gate));
        write_reg(REG_TYPE_SEL, APB_W'(pick));
        cur_mode    = mode;
        cur_owner   = who;
        cur_kind_en = gate;
        cur_kind    = pick;
    endtask

    // Drop valid, wait for every outstanding rank, then let the pipe empty.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (ranks_due != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_record(record_t r);
        while (!steady && $urandom_range(99) < 8)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(REC_W-METRIC_W-2*XY_W-OWN_W){1'b0}},
                          r.owner, r.y, r.x, r.metric};
        s_axis_tuser  <= r.kind;
        s_axis_tlast  <= r.closing;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    function automatic record_t mk(logic [METRIC_W-1:0] metric, logic [7:0] x,
                                   logic [7:0] y, logic [3:0] kind,
                                   logic [5:0] owner, logic closing);
        record_t r;
        r.metric  = metric;
        r.x       = x;
        r.y       = y;
        r.kind    = kind;
        r.owner   = owner;
        r.closing = closing;
        return r;
    endfunction

    // Mostly records that pass the current filters; ties come from small metrics.
    function automatic record_t roll_record(logic closing);
        record_t r;
        int      pick;
        pick = $urandom_range(99);
        if (pick < 40)
            r.metric = METRIC_W'($urandom());
        else if (pick < 80)
            r.metric = METRIC_W'($urandom_range(7));
        else if (pick < 90)
            r.metric = '0;
        else
            r.metric = METRIC_TOP;
        r.x = XY_W'($urandom());
        r.y = XY_W'($urandom());
        if ($urandom_range(99) < 80)
        begin
            r.kind = cur_kind_en ? cur_kind : 4'($urandom_range(8));
            case (cur_mode)
                OWN_FREE: r.owner = '0;
                OWN_ONE:  r.owner = cur_owner;
                default:  r.owner = OWN_W'($urandom());
            endcase
        end
        else
        begin
            r.kind  = KIND_W'($urandom());
            r.owner = OWN_W'($urandom());
        end
        r.closing = closing;
        return r;
    endfunction

    task automatic send_run(int len);
        int k;
        for (k = 0; k < len; k++)
        begin
            send_record(roll_record(k == len - 1));
            random_sent++;
        end
    endtask

    initial
    begin
        int phase;
        int runs;
        int len;
        cur_mode    = OWN_ALL;
        cur_owner   = '0;
        cur_kind_en = 1'b0;
        cur_kind    = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: a lone final record at the top value and field extremes.
        send_record(mk(METRIC_TOP, 8'hFF, 8'hFF, 4'hF, 6'h3F, 1'b1));
        // Overflow with ties: earlier equal records stay ahead, the smallest drop.
        send_record(mk('0, 8'd1, 8'd1, 4'd1, 6'd1, 1'b0));
        send_record(mk(METRIC_TOP, 8'd2, 8'd2, 4'd2, 6'd2, 1'b0));
        send_record(mk(31'd5, 8'd3, 8'd3, 4'd3, 6'd3, 1'b0));
        send_record(mk(31'd5, 8'd4, 8'd4, 4'd4, 6'd4, 1'b0));
        send_record(mk(31'd5, 8'd5, 8'd5, 4'd5, 6'd5, 1'b0));
        send_record(mk(31'd1, 8'd6, 8'd6, 4'd6, 6'd6, 1'b0));
        send_record(mk(31'd3, 8'd7, 8'd7, 4'd7, 6'd7, 1'b1));
        settle();

        // Lowest first, unoccupied only, type select beyond the defined codes.
        configure(ORDER_LOW, OWN_FREE, 6'h3F, 1'b1, 4'hF);
        send_record(mk(31'd9, 8'h10, 8'h20, 4'hF, 6'd0, 1'b0));
        send_record(mk(31'd2, 8'h11, 8'h21, 4'hF, 6'd5, 1'b0));
        send_record(mk(31'd1, 8'h12, 8'h22, 4'd8, 6'd0, 1'b0));
        send_record(mk('0, 8'h13, 8'h23, 4'hF, 6'd0, 1'b0));
        send_record(mk(31'd9, 8'h14, 8'h24, 4'hF, 6'd0, 1'b1));
        settle();

        // One specific owner, and that owner is zero.
        configure(ORDER_HIGH, OWN_ONE, 6'd0, 1'b0, 4'd8);
        send_record(mk(31'd20, 8'h30, 8'h40, 4'd3, 6'd0, 1'b0));
        send_record(mk(31'd30, 8'h31, 8'h41, 4'd3, 6'd1, 1'b0));
        send_record(mk(31'd20, 8'h32, 8'h42, 4'd8, 6'd0, 1'b1));
        settle();

        // Undefined owner mode: the run comes out all empty.
        configure(ORDER_HIGH, OWN_NONE, 6'd0, 1'b0, 4'd0);
        send_record(mk(31'd100, 8'h50, 8'h60, 4'd0, 6'd0, 1'b0));
        send_record(mk(31'd200, 8'h51, 8'h61, 4'd0, 6'd0, 1'b1));
        settle();

        configure(ORDER_LOW, OWN_ONE, 6'h3F, 1'b1, 4'd0);
        send_record(mk(METRIC_TOP, 8'h00, 8'h00, 4'd0, 6'h3F, 1'b0));
        send_record(mk(31'd4, 8'h01, 8'h01, 4'd1, 6'h3F, 1'b0));
        send_record(mk(METRIC_TOP, 8'h02, 8'h02, 4'd0, 6'h3F, 1'b1));
        settle();

        phase = 0;
        while (random_sent < RANDOM_RECORDS)
        begin
            if (phase == 0)
                configure(ORDER_HIGH, OWN_ALL, 6'h3F, 1'b1, 4'd8);
            else if (phase == 1)
                configure(ORDER_LOW, OWN_ONE, 6'h00, 1'b0, 4'hF);
            else
                configure(1'($urandom_range(1)),
                          ($urandom_range(99) < 10) ? OWN_NONE : 2'($urandom_range(2)),
                          6'($urandom()), 1'($urandom_range(1)),
                          ($urandom_range(99) < 80) ? 4'($urandom_range(8))
                                                    : 4'($urandom_range(15, 9)));
            steady <= (phase < 2);
            // Stop the receiver for a long stretch while short runs pile up.
            if (phase == 1)
                holdoff_asked <= holdoff_asked + 1;
            for (runs = 0; runs < 3; runs++)
            begin
                if (phase == 1)
                    len = $urandom_range(3, 1);
                else if ($urandom_range(99) < 85)
                    len = $urandom_range(8, 1);
                else
                    len = 12;
                send_run(len);
                // Hold the sender until every outstanding rank is out.
                if (phase % 3 == 2 && runs == 0)
                    settle();
            end
            settle();
            phase++;
        end

        if (mismatches == 0 && ranks_due == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/ftk_pkg.sv
rtl/core/ftk_rank_list.sv
rtl/core/filtered_top_k_tracker_unit.sv
sim/ftk_rank_checker.sv
sim/filtered_top_k_tracker_unit_test.sv
